// File: rtl/core/oudc_pkg.sv
// shared types, constants and helpers of the online unit disk cover block
// no dependencies; used by the interfaces, the cell chain and the top level

package oudc_pkg;

	localparam int COORD_W     = 24;
	localparam int FRAC_BITS   = 8;
	localparam int LIMIT_W     = 32;
	localparam int MAX_COVERED = 256;
	localparam int IDX_W       = $clog2(MAX_COVERED);
	localparam int CNT_W       = $clog2(MAX_COVERED + 1);
	localparam int DIFF_W      = COORD_W + 1;
	localparam int SQ_W        = 2 * COORD_W + 1;
	localparam int DIST_W      = SQ_W + 1;

	localparam int SQRT3_Q16   = 113512;
	localparam int SQRT3_FX    = ((SQRT3_Q16 * 2) + (1 << (16 - FRAC_BITS))) >> (17 - FRAC_BITS);
	localparam int HSQRT3_FX   = (SQRT3_Q16 + (1 << (16 - FRAC_BITS))) >> (17 - FRAC_BITS);
	localparam int ONE_HALF_FX = 3 << (FRAC_BITS - 1);

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(2 << (2 * FRAC_BITS));

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [COORD_W:0]   ofs_t;
	typedef logic [IDX_W-1:0]          idx_t;
	typedef logic [CNT_W-1:0]          cnt_t;
	typedef logic [LIMIT_W-1:0]        limit_t;

	localparam ofs_t OFS_ZERO     = ofs_t'(0);
	localparam ofs_t OFS_SQRT3    = ofs_t'(SQRT3_FX);
	localparam ofs_t OFS_HSQRT3   = ofs_t'(HSQRT3_FX);
	localparam ofs_t OFS_HALF_UP  = ofs_t'(ONE_HALF_FX);
	localparam ofs_t OFS_HALF_DN  = ofs_t'(-ONE_HALF_FX);

	localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	// query travelling down the chain
	typedef struct packed {
		logic   valid;
		coord_t x;
		coord_t y;
		logic   hit;
	} query_t;

	// table control broadcast to all cells
	typedef struct packed {
		logic   clr;
		logic   en;
		idx_t   idx;
		coord_t x;
		coord_t y;
	} table_wr_t;

	function automatic coord_t add_sat(coord_t a, ofs_t b);
		ofs_t s;
		s = {a[COORD_W-1], a} + b;
		if (s[COORD_W] != s[COORD_W-1]) begin
			return s[COORD_W] ? COORD_MIN : COORD_MAX;
		end
		return s[COORD_W-1:0];
	endfunction

endpackage

// File: rtl/core/oudc_if.sv
// valid/ready channel interfaces for points in and disk centers out
// depends on oudc_pkg

interface oudc_point_if;
	import oudc_pkg::*;
	logic   valid;
	logic   ready;
	coord_t point_x;
	coord_t point_y;
	logic   new_set;

	modport source(output valid, output point_x, output point_y, output new_set, input ready);
	modport sink(input valid, input point_x, input point_y, input new_set, output ready);
endinterface

interface oudc_center_if;
	import oudc_pkg::*;
	logic   valid;
	logic   ready;
	coord_t center_x;
	coord_t center_y;
	logic   last_center;
	logic   table_full;

	modport source(output valid, output center_x, output center_y, output last_center,
		output table_full, input ready);
	modport sink(input valid, input center_x, input center_y, input last_center,
		input table_full, output ready);
endinterface

// File: rtl/core/oudc_cell.sv
// one cell of the cover chain: holds one covered point, checks the passing query
// depends on oudc_pkg

module oudc_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  oudc_pkg::idx_t      cell_idx,
	input  oudc_pkg::limit_t    limit,
	input  oudc_pkg::table_wr_t wr,
	input  oudc_pkg::query_t    q_in,
	output oudc_pkg::query_t    q_out
);
	import oudc_pkg::*;

	logic                 valid_q;
	coord_t               px_q;
	coord_t               py_q;
	query_t               q_s1;
	logic                 on_s1;
	logic [SQ_W-1:0]      sqx_s1;
	logic [SQ_W-1:0]      sqy_s1;
	query_t               q_s2;
	logic signed [DIFF_W-1:0]   dx;
	logic signed [DIFF_W-1:0]   dy;
	logic signed [2*DIFF_W-1:0] px2;
	logic signed [2*DIFF_W-1:0] py2;
	logic [DIST_W-1:0]    dsum;
	logic                 close;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr.en && wr.idx == cell_idx) begin
			valid_q <= 1'b1;
		end else if (wr.clr) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && wr.idx == cell_idx) begin
			px_q <= wr.x;
			py_q <= wr.y;
		end
	end

	assign dx  = {q_in.x[COORD_W-1], q_in.x} - {px_q[COORD_W-1], px_q};
	assign dy  = {q_in.y[COORD_W-1], q_in.y} - {py_q[COORD_W-1], py_q};
	assign px2 = dx * dx;
	assign py2 = dy * dy;

	assign dsum  = DIST_W'(sqx_s1) + DIST_W'(sqy_s1);
	assign close = on_s1 && (dsum <= DIST_W'(limit));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_s1 <= '0;
			q_s2 <= '0;
		end else begin
			q_s1 <= q_in;
			q_s2 <= {q_s1.valid, q_s1.x, q_s1.y, q_s1.hit | close};
		end
	end

	always_ff @(posedge clk) begin
		on_s1    <= valid_q;
		sqx_s1   <= px2[SQ_W-1:0];
		sqy_s1   <= py2[SQ_W-1:0];
	end

	assign q_out = q_s2;

endmodule

// File: rtl/core/oudc_chain.sv
// row of cover cells; the query enters at cell 0 and leaves after the last cell
// depends on oudc_pkg and oudc_cell

module oudc_chain (
	input  logic                clk,
	input  logic                arst_n,
	input  oudc_pkg::limit_t    limit,
	input  oudc_pkg::table_wr_t wr,
	input  oudc_pkg::query_t    head,
	output oudc_pkg::query_t    tail
);
	import oudc_pkg::*;

	query_t links [MAX_COVERED+1];

	assign links[0] = head;

	for (genvar i = 0; i < MAX_COVERED; i++) begin : g_cell
		oudc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (idx_t'(i)),
			.limit    (limit),
			.wr       (wr),
			.q_in     (links[i]),
			.q_out    (links[i+1])
		);
	end

	assign tail = links[MAX_COVERED];

endmodule

// File: rtl/core/online_unit_disk_cover.sv
// top level of the online unit disk cover block: control, table count, center output
// depends on oudc_pkg, oudc_if and oudc_chain
//
//  channel   dir  handshake        payload
//  points    in   valid / ready    point_x, point_y, new_set
//  centers   out  valid / ready    center_x, center_y, last_center, table_full
//  cfg       in   cfg_we           cfg_wdata (cover_limit_sq)
//
// a point searches the cell chain, passing through two registers per cell
// a point that needs disks then issues four centers, one per cycle unless stalled
// one point at a time; points.ready is high only while no search or issue is running
// the last center may wait in the output register while the next point is taken
// reset empties the table and sets the limit to 2.0

module online_unit_disk_cover (
	input  logic                 clk,
	input  logic                 arst_n,
	oudc_point_if.sink           points,
	oudc_center_if.source        centers,
	input  logic                 cfg_we,
	input  oudc_pkg::limit_t     cfg_wdata
);
	import oudc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SEARCH = 3'b010,
		ST_EMIT   = 3'b100
	} state_t;

	state_t    state_q;
	limit_t    limit_q;
	cnt_t      count_q;
	logic      inj_q;
	coord_t    px_q;
	coord_t    py_q;
	logic      full_q;
	logic [1:0] k_q;
	logic      out_v_q;
	coord_t    cx_q;
	coord_t    cy_q;
	logic      last_q;
	logic      ofull_q;

	query_t    head;
	query_t    tail;
	table_wr_t wr;
	logic      accept;
	logic      count_full;
	logic      load;
	logic      need;
	ofs_t      ofs_x;
	ofs_t      ofs_y;

	assign points.ready = (state_q == ST_IDLE);
	assign accept       = points.valid && points.ready;
	assign count_full   = (count_q == cnt_t'(MAX_COVERED));
	assign need         = (state_q == ST_SEARCH) && tail.valid && !tail.hit;

	assign head.valid = inj_q;
	assign head.x     = px_q;
	assign head.y     = py_q;
	assign head.hit   = 1'b0;

	assign wr.clr = accept && points.new_set;
	assign wr.en  = need && !count_full;
	assign wr.idx = count_q[IDX_W-1:0];
	assign wr.x   = px_q;
	assign wr.y   = py_q;

	oudc_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.limit  (limit_q),
		.wr     (wr),
		.head   (head),
		.tail   (tail)
	);

	assign load = (state_q == ST_EMIT) && (!out_v_q || centers.ready);

	always_comb begin
		case (k_q)
			2'd0: begin
				ofs_x = OFS_ZERO;
				ofs_y = OFS_ZERO;
			end
			2'd1: begin
				ofs_x = OFS_SQRT3;
				ofs_y = OFS_ZERO;
			end
			2'd2: begin
				ofs_x = OFS_HSQRT3;
				ofs_y = OFS_HALF_UP;
			end
			default: begin
				ofs_x = OFS_HSQRT3;
				ofs_y = OFS_HALF_DN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			limit_q <= LIMIT_RESET;
			count_q <= '0;
			inj_q   <= 1'b0;
			k_q     <= '0;
			out_v_q <= 1'b0;
		end else begin
			inj_q <= 1'b0;
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (load) begin
				out_v_q <= 1'b1;
			end else if (centers.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						inj_q   <= 1'b1;
						state_q <= ST_SEARCH;
						if (points.new_set) begin
							count_q <= '0;
						end
					end
				end
				ST_SEARCH: begin
					if (tail.valid) begin
						if (tail.hit) begin
							state_q <= ST_IDLE;
						end else begin
							if (!count_full) begin
								count_q <= count_q + cnt_t'(1);
							end
							k_q     <= '0;
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (load) begin
						k_q <= k_q + 2'd1;
						if (k_q == 2'd3) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_q <= points.point_x;
			py_q <= points.point_y;
		end
		if (need) begin
			full_q <= count_full;
		end
		if (load) begin
			cx_q    <= add_sat(px_q, ofs_x);
			cy_q    <= add_sat(py_q, ofs_y);
			last_q  <= (k_q == 2'd3);
			ofull_q <= full_q;
		end
	end

	assign centers.valid       = out_v_q;
	assign centers.center_x    = cx_q;
	assign centers.center_y    = cy_q;
	assign centers.last_center = last_q;
	assign centers.table_full  = ofull_q;

	a_inject_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		inj_q |-> state_q == ST_SEARCH)
		else $error("query injected outside search");

	a_tail_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		tail.valid |-> state_q == ST_SEARCH)
		else $error("chain result outside search");

	a_no_write_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> count_q < cnt_t'(MAX_COVERED))
		else $error("table write past capacity");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cnt_t'(MAX_COVERED))
		else $error("covered count out of range");

	a_group_ends_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(load && k_q == 2'd3) |=> state_q == ST_IDLE)
		else $error("fourth center did not end the group");

endmodule

// File: tb/sv/online_unit_disk_cover_checker.sv
`timescale 1ns / 1ps
// checker for the online unit disk cover block: watches the point, center and cfg ports,
// predicts the four centers of each point that needs disks and compares them in order
// depends on oudc_pkg and the oudc_point_if / oudc_center_if interfaces

module online_unit_disk_cover_checker
	import oudc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	oudc_point_if       pts,
	oudc_center_if      ctrs,
	input  logic        cfg_we,
	input  limit_t      cfg_wdata,
	output int unsigned fail_count,
	output int unsigned pending,
	output int unsigned n_points,
	output int unsigned n_centers,
	output int unsigned n_full
);

	// sqrt3, sqrt3/2 and 1.5 in Q15.8
	localparam longint STEP_R3      = 443;
	localparam longint STEP_HALF_R3 = 222;
	localparam longint STEP_Y       = 384;

	typedef struct packed {
		coord_t x;
		coord_t y;
		logic   tail;
		logic   full;
	} center_t;

	coord_t      covered_x [MAX_COVERED];
	coord_t      covered_y [MAX_COVERED];
	int unsigned covered_cnt;
	limit_t      limit_sq;
	center_t     centers_due [$];
	center_t     due;

	function automatic coord_t clamp_coord(input longint v);
		if (v > longint'(COORD_MAX)) begin
			return COORD_MAX;
		end
		if (v < longint'(COORD_MIN)) begin
			return COORD_MIN;
		end
		return coord_t'(v);
	endfunction

	task automatic push_center(input longint x, input longint y, input logic tail,
		input logic full);
		center_t c;
		c.x = clamp_coord(x);
		c.y = clamp_coord(y);
		c.tail = tail;
		c.full = full;
		centers_due = {centers_due, c};
	endtask

	task automatic predict_cover(input coord_t px, input coord_t py, input logic clear);
		longint dx;
		longint dy;
		longint d;
		longint nearest;
		logic   need;
		logic   full;
		if (clear) begin
			covered_cnt = 0;
		end
		need = 1'b1;
		full = 1'b0;
		if (covered_cnt > 0) begin
			nearest = 64'sh7FFF_FFFF_FFFF_FFFF;
			for (int i = 0; i < covered_cnt; i++) begin
				dx = longint'(px) - longint'(covered_x[i]);
				dy = longint'(py) - longint'(covered_y[i]);
				d = dx * dx + dy * dy;
				if (d < nearest) begin
					nearest = d;
				end
			end
			need = nearest > longint'({32'd0, limit_sq});
		end
		if (need) begin
			if (covered_cnt < MAX_COVERED) begin
				covered_x[covered_cnt] = px;
				covered_y[covered_cnt] = py;
				covered_cnt++;
			end else begin
				full = 1'b1;
			end
			push_center(px, py, 1'b0, full);
			push_center(px + STEP_R3, py, 1'b0, full);
			push_center(px + STEP_HALF_R3, py + STEP_Y, 1'b0, full);
			push_center(px + STEP_HALF_R3, py - STEP_Y, 1'b1, full);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			covered_cnt = 0;
			limit_sq = 32'd131072;
			centers_due.delete();
			fail_count = 0;
			pending = 0;
			n_points = 0;
			n_centers = 0;
			n_full = 0;
		end else begin
			if (cfg_we) begin
				limit_sq = cfg_wdata;
			end
			if (pts.valid && pts.ready) begin
				predict_cover(pts.point_x, pts.point_y, pts.new_set);
				n_points++;
			end
			if (ctrs.valid && ctrs.ready) begin
				n_centers++;
				if (ctrs.table_full === 1'b1) begin
					n_full++;
				end
				if (centers_due.size() == 0) begin
					$error("center transaction with none expected: x=%0d y=%0d",
						ctrs.center_x, ctrs.center_y);
					fail_count++;
				end else begin
					due = centers_due.pop_front();
					if (ctrs.center_x !== due.x) begin
						$error("center_x expected %0d actual %0d", due.x, ctrs.center_x);
						fail_count++;
					end
					if (ctrs.center_y !== due.y) begin
						$error("center_y expected %0d actual %0d", due.y, ctrs.center_y);
						fail_count++;
					end
					if (ctrs.last_center !== due.tail) begin
						$error("last_center expected %0b actual %0b", due.tail,
							ctrs.last_center);
						fail_count++;
					end
					if (ctrs.table_full !== due.full) begin
						$error("table_full expected %0b actual %0b", due.full,
							ctrs.table_full);
						fail_count++;
					end
				end
			end
			pending = centers_due.size();
		end
	end

endmodule

// File: tb/sv/online_unit_disk_cover_tb.sv
`timescale 1ns / 1ps
// top of the online unit disk cover testbench: clock, reset, point stimulus, limit writes
// and the verdict; depends on oudc_pkg, the oudc interfaces, the block and its checker

module online_unit_disk_cover_tb;
	import oudc_pkg::*;

	localparam int SEARCH_CYCLES  = 2 * MAX_COVERED + 2;
	localparam int SETTLE_CYCLES  = SEARCH_CYCLES + 8;
	localparam int WATCHDOG_LIMIT = 8 * SEARCH_CYCLES;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	limit_t      cfg_wdata;
	int unsigned send_idle;
	int unsigned recv_idle;
	int unsigned quiet;
	int unsigned fail_count;
	int unsigned pending;
	int unsigned n_points;
	int unsigned n_centers;
	int unsigned n_full;

	oudc_point_if  pt_bus();
	oudc_center_if ctr_bus();

	online_unit_disk_cover dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.points    (pt_bus),
		.centers   (ctr_bus),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	online_unit_disk_cover_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.pts        (pt_bus),
		.ctrs       (ctr_bus),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending),
		.n_points   (n_points),
		.n_centers  (n_centers),
		.n_full     (n_full)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		ctr_bus.ready <= ($urandom_range(99) >= recv_idle);
	end

	initial begin
		quiet = 0;
	end

	always @(posedge clk) begin
		if ((pt_bus.valid && pt_bus.ready) || (ctr_bus.valid && ctr_bus.ready) || cfg_we) begin
			quiet = 0;
		end else begin
			quiet++;
		end
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", quiet);
			$display("status: fail");
			$finish;
		end
	end

	function automatic coord_t fit_coord(input longint v);
		if (v > longint'(COORD_MAX)) begin
			return COORD_MAX;
		end
		if (v < longint'(COORD_MIN)) begin
			return COORD_MIN;
		end
		return coord_t'(v);
	endfunction

	// called at a falling edge; returns at the falling edge after the transaction
	task automatic send_point(input coord_t x, input coord_t y, input logic clear);
		while ($urandom_range(99) < send_idle) begin
			pt_bus.valid <= 1'b0;
			@(negedge clk);
		end
		pt_bus.valid <= 1'b1;
		pt_bus.point_x <= x;
		pt_bus.point_y <= y;
		pt_bus.new_set <= clear;
		@(posedge clk);
		while (!pt_bus.ready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	// waits until the block is idle, then writes the limit
	task automatic write_limit(input limit_t v);
		pt_bus.valid <= 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// sorted runs of nearby points with occasional new sets and stray points
	task automatic rand_burst(input int n, input int span);
		longint cx;
		longint cy;
		longint step;
		logic   clear;
		cx = 0;
		cy = 0;
		for (int k = 0; k < n; k++) begin
			clear = 1'b0;
			if (k == 0 || $urandom_range(19) == 0) begin
				clear = 1'b1;
				case ($urandom_range(3))
					0: begin
						cx = longint'(COORD_MAX) - longint'($urandom_range(span));
					end
					1: begin
						cx = longint'(COORD_MIN);
					end
					default: begin
						cx = longint'(coord_t'($urandom));
					end
				endcase
				cy = longint'(coord_t'($urandom));
				send_point(fit_coord(cx), fit_coord(cy), clear);
			end else if ($urandom_range(9) == 0) begin
				send_point(coord_t'($urandom), coord_t'($urandom), $urandom_range(3) == 0);
			end else begin
				step = longint'($urandom_range(span));
				cx = cx + step;
				if (step == 0) begin
					cy = cy + longint'($urandom_range(span, 1));
				end else begin
					cy = cy + longint'($urandom_range(2 * span)) - span;
				end
				cx = longint'(fit_coord(cx));
				cy = longint'(fit_coord(cy));
				send_point(coord_t'(cx), coord_t'(cy), clear);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		pt_bus.valid = 1'b0;
		pt_bus.point_x = '0;
		pt_bus.point_y = '0;
		pt_bus.new_set = 1'b0;
		ctr_bus.ready = 1'b0;
		send_idle = 30;
		recv_idle = 62;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// default limit of 2.0: boundary distance, saturation, repeats and set clearing
		send_point(coord_t'(0), coord_t'(0), 1'b1);
		send_point(coord_t'(256), coord_t'(256), 1'b0);
		send_point(coord_t'(257), coord_t'(256), 1'b0);
		send_point(coord_t'(257), coord_t'(256), 1'b0);
		send_point(COORD_MAX, COORD_MAX, 1'b1);
		send_point(COORD_MIN, COORD_MIN, 1'b0);
		send_point(COORD_MIN, COORD_MAX, 1'b0);
		send_point(COORD_MAX, COORD_MIN, 1'b0);
		send_point(coord_t'(-1), coord_t'(-1), 1'b0);
		send_point(coord_t'(24'h555555), coord_t'(24'hAAAAAA), 1'b0);
		send_point(COORD_MAX, COORD_MAX, 1'b0);
		send_point(coord_t'(-1), coord_t'(0), 1'b1);
		rand_burst(50, 600);

		write_limit(32'hFFFF_FFFF);
		send_idle = 62;
		recv_idle = 30;
		rand_burst(45, 100000);

		write_limit(limit_t'($urandom_range(4194304, 1024)));
		send_idle = 0;
		recv_idle = 0;
		rand_burst(40, 3000);

		// zero limit: every distinct point is stored, an exact repeat is covered
		write_limit(32'd0);
		for (int i = 0; i < 20; i++) begin
			send_point(coord_t'(-4000 + 9 * i), coord_t'((i % 5) * 100), i == 0);
		end
		send_point(coord_t'(-4000), coord_t'(0), 1'b0);
		send_point(COORD_MAX, coord_t'(0), 1'b0);
		send_point(coord_t'(5), coord_t'(5), 1'b1);

		pt_bus.valid <= 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("summary: %0d points, %0d centers checked, %0d table-full groups",
			n_points, n_centers, n_full / 4);
		$display("summary: limits zero, 2.0, mid and max; clamping at both coordinate ends");
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/oudc_pkg.sv
rtl/core/oudc_if.sv
rtl/core/oudc_cell.sv
rtl/core/oudc_chain.sv
rtl/core/online_unit_disk_cover.sv
tb/sv/online_unit_disk_cover_checker.sv
tb/sv/online_unit_disk_cover_tb.sv
